// ===== hdl/ohao_pkg.sv =====
// shared types, constants and elaboration-time tables for the odd-harmonic oscillator
`default_nettype none

package ohao_pkg;

    // fixed formats
    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_RATE      = 44100;
    localparam int NOTE_BITS        = 7;
    localparam int NOTE_COUNT       = 1 << NOTE_BITS;
    localparam int LEVEL_BITS       = 16;
    localparam int HARM_BITS        = 8;
    localparam int SAMPLE_BITS      = 24;

    // quarter-wave table: depth is a power of two, entries in Q1.30 (0 .. 2^30)
    localparam int SINE_IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_ADDR_BITS = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SINE_FRAC_BITS = 30;
    localparam int SINE_BITS      = SINE_FRAC_BITS + 1;

    // level * sine is Q16.30 and always below 2^46
    localparam int PROD_BITS      = LEVEL_BITS + SINE_FRAC_BITS;
    localparam int DIV_STAGE_BITS = 8;
    localparam int DIV_STAGES     = (PROD_BITS + DIV_STAGE_BITS - 1) / DIV_STAGE_BITS;
    localparam int DIV_BITS       = DIV_STAGES * DIV_STAGE_BITS;

    // sum of at most 128 terms, each below 2^46 / i
    localparam int ACC_BITS    = PROD_BITS + 4;
    localparam int FRAC_DROP   = PROD_BITS - (SAMPLE_BITS - 1);
    localparam int SCALED_BITS = ACC_BITS - FRAC_DROP;

    localparam logic [HARM_BITS-1:0] MAX_HARMONIC_RESET = HARM_BITS'(180);

    typedef logic [PHASE_BITS-1:0] t_phase;
    typedef logic [SINE_BITS-1:0]  t_sine;
    typedef t_sine  t_sine_table [0:SINE_TABLE_DEPTH];
    typedef t_phase t_inc_table  [0:NOTE_COUNT-1];

    // handshake tag that travels alongside a term through the divider
    typedef struct packed {
        logic valid;
        logic neg;
    } t_div_tag;

    // 2^((k-9)/12) scaled by 10^12
    localparam logic [63:0] SEMITONE_RATIO [0:11] = '{
        64'd594603557501,  64'd629960524947,  64'd667419927085,  64'd707106781187,
        64'd749153538438,  64'd793700525984,  64'd840896415254,  64'd890898718140,
        64'd943874312682,  64'd1000000000000, 64'd1059463094359, 64'd1122462048309
    };

    localparam logic [63:0] RATIO_SCALE = 64'd1000000000000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << SINE_FRAC_BITS;

    // (2k)(2k+1) for the taylor terms
    localparam logic [63:0] TAYLOR_DIV [1:9] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    // per-sample phase increment for each note, rounded half up by long division
    function automatic t_inc_table build_inc_table();
        t_inc_table  tbl;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] res;
        int          e;
        den = 64'(SAMPLE_RATE) * RATIO_SCALE;
        for (int n = 0; n < NOTE_COUNT; n++) begin
            num = 64'd440 * SEMITONE_RATIO[n % 12];
            e   = PHASE_BITS + n / 12 - 5;
            rem = num;
            res = '0;
            for (int b = 0; b <= e; b++) begin
                rem = rem << 1;
                res = res << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    res = res | 64'd1;
                end
            end
            tbl[n] = PHASE_BITS'((res + 64'd1) >> 1);
        end
        return tbl;
    endfunction

    // quarter sine in Q30 via truncated taylor series up to x^19, clamped to [0, 1.0]
    function automatic t_sine_table build_sine_table();
        t_sine_table       tbl;
        logic [63:0]       x;
        logic [63:0]       mag;
        logic signed [63:0] sum;
        for (int j = 0; j <= SINE_TABLE_DEPTH; j++) begin
            x   = (HALF_PI_Q30 * 64'(j) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
            mag = x;
            sum = $signed(x);
            for (int k = 1; k <= 9; k++) begin
                mag = (mag * x) >> SINE_FRAC_BITS;
                mag = (mag * x) >> SINE_FRAC_BITS;
                mag = mag / TAYLOR_DIV[k];
                if ((k % 2) == 1) begin
                    sum = sum - $signed(mag);
                end else begin
                    sum = sum + $signed(mag);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            if (sum > $signed(ONE_Q30)) begin
                sum = $signed(ONE_Q30);
            end
            tbl[j] = SINE_BITS'(sum);
        end
        return tbl;
    endfunction

    localparam t_inc_table INC_TABLE = build_inc_table();

endpackage

`default_nettype wire

// ===== hdl/ohao_sine_rom.sv =====
// quarter-wave sine rom with registered read port
`default_nettype none

module ohao_sine_rom
    import ohao_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [SINE_ADDR_BITS-1:0] i_addr,
    output t_sine                     o_data
);

    localparam t_sine_table SINE_ROM = build_sine_table();

    t_sine r_data;

    // synchronous read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== hdl/ohao_div_pipe.sv =====
// pipelined unsigned divider of a term by its odd harmonic number, one term per cycle
`default_nettype none

module ohao_div_pipe
    import ohao_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_tag             i_tag,
    input  logic [PROD_BITS-1:0] i_dividend,
    input  logic [HARM_BITS-1:0] i_divisor,
    output t_div_tag             o_tag,
    output logic [PROD_BITS-1:0] o_quotient
);

    // dividend shifts out at the top while quotient bits shift in at the bottom
    t_div_tag             r_tag [DIV_STAGES];
    logic [DIV_BITS-1:0]  r_num [DIV_STAGES];
    logic [HARM_BITS-1:0] r_rem [DIV_STAGES-1];
    logic [HARM_BITS-1:0] r_div [DIV_STAGES-1];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        t_div_tag             w_tag_in;
        logic [DIV_BITS-1:0]  w_num_in;
        logic [HARM_BITS-1:0] w_rem_in;
        logic [HARM_BITS-1:0] w_div_in;
        logic [DIV_BITS-1:0]  n_num;
        logic [HARM_BITS-1:0] n_rem;

        if (s == 0) begin : g_head
            assign w_tag_in = i_tag;
            assign w_num_in = DIV_BITS'(i_dividend);
            assign w_rem_in = '0;
            assign w_div_in = i_divisor;
        end else begin : g_body
            assign w_tag_in = r_tag[s-1];
            assign w_num_in = r_num[s-1];
            assign w_rem_in = r_rem[s-1];
            assign w_div_in = r_div[s-1];
        end

        // restoring steps; remainder stays below the divisor so each step is narrow
        always_comb begin : p_steps
            logic [HARM_BITS:0] trial;
            n_num = w_num_in;
            n_rem = w_rem_in;
            trial = '0;
            for (int b = 0; b < DIV_STAGE_BITS; b++) begin
                trial = {n_rem, n_num[DIV_BITS-1]};
                n_num = {n_num[DIV_BITS-2:0], 1'b0};
                if (trial >= {1'b0, w_div_in}) begin
                    trial    = trial - {1'b0, w_div_in};
                    n_num[0] = 1'b1;
                end
                n_rem = trial[HARM_BITS-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else begin
                r_tag[s] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[s] <= n_num;
        end

        if (s < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem;
                r_div[s] <= w_div_in;
            end
        end
    end

    assign o_tag      = r_tag[DIV_STAGES-1];
    assign o_quotient = r_num[DIV_STAGES-1][PROD_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/odd_harmonic_additive_oscillator_unit.sv =====
// top level of the odd-harmonic additive oscillator: sequencer, phase, product and sum
//
//  channel | direction | signals                                      | payload
//  --------+-----------+----------------------------------------------+------------------------
//  in      | to block  | i_in_valid / o_in_ready                      | i_note, i_level, i_restart
//  out     | from block| o_out_valid / i_out_ready                    | o_sample
//  cfg     | to block  | i_cfg_valid / o_cfg_ready (always ready)     | i_cfg_max_harmonic
//
//  one term is issued per cycle to the sine rom, one for each of the n odd harmonics up
//  to max_harmonic (90 at reset); each term passes the rom read, the multiply, six
//  divider stages and the accumulator, and no new input is taken until the sum is registered.
//  reset clears control and sets max_harmonic to 180 and the phase to zero. a stalled
//  output holds its sample while the next item is taken in; the new sum waits for the
//  output register to free first.
`default_nettype none

module odd_harmonic_additive_oscillator_unit
    import ohao_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [NOTE_BITS-1:0]          i_note,
    input  logic [LEVEL_BITS-1:0]         i_level,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [HARM_BITS-1:0]          i_cfg_max_harmonic
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    localparam logic signed [ACC_BITS-1:0]    ROUND_HALF = ACC_BITS'(1) <<< (FRAC_DROP - 1);
    localparam logic signed [SCALED_BITS-1:0] SAT_HI =
        SCALED_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SCALED_BITS-1:0] SAT_LO = -SAT_HI - SCALED_BITS'(1);

    t_state                         r_state;
    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_sample;
    logic [HARM_BITS-1:0]           r_max_harmonic;
    t_phase                         r_base_phase;
    logic [HARM_BITS-1:0]           r_left;
    logic [HARM_BITS-1:0]           r_pend;

    t_phase                         r_hp;
    t_phase                         r_step;
    logic [HARM_BITS-1:0]           r_harm;
    logic [LEVEL_BITS-1:0]          r_level;
    logic signed [ACC_BITS-1:0]     r_acc;

    logic                           r_a_valid;
    logic                           r_a_neg;
    logic [HARM_BITS-1:0]           r_a_harm;
    logic                           r_b_valid;
    logic                           r_b_neg;
    logic [HARM_BITS-1:0]           r_b_harm;
    logic [PROD_BITS-1:0]           r_b_prod;

    logic                           w_in_xfer;
    logic                           w_out_xfer;
    logic                           w_issue;
    logic                           w_finish;
    t_phase                         w_start_phase;
    logic [HARM_BITS-1:0]           w_terms;
    logic [SINE_IDX_BITS-1:0]       w_idx;
    logic [SINE_ADDR_BITS-1:0]      w_addr;
    t_sine                          w_sine;
    t_div_tag                       w_b_tag;
    t_div_tag                       w_q_tag;
    logic [PROD_BITS-1:0]           w_quot;
    logic signed [ACC_BITS-1:0]     w_term;
    logic signed [ACC_BITS-1:0]     w_rounded;
    logic signed [SCALED_BITS-1:0]  w_scaled;
    logic signed [SAMPLE_BITS-1:0]  w_sat;

    // handshakes
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign w_in_xfer   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_xfer  = r_out_valid && i_out_ready;

    // start of a sample: phase before advance, number of odd harmonics
    assign w_start_phase = i_restart ? '0 : r_base_phase;
    assign w_terms       = HARM_BITS'(({1'b0, r_max_harmonic} + (HARM_BITS + 1)'(1)) >> 1);

    assign w_issue  = (r_state == ST_RUN) && (r_left != '0);
    assign w_finish = (r_state == ST_RUN) && (r_pend == '0) && (!r_out_valid || i_out_ready);

    // quadrant and mirrored quarter-wave address
    assign w_idx  = r_hp[PHASE_BITS-3 -: SINE_IDX_BITS];
    assign w_addr = r_hp[PHASE_BITS-2] ?
                    SINE_ADDR_BITS'(SINE_TABLE_DEPTH) - SINE_ADDR_BITS'(w_idx) :
                    SINE_ADDR_BITS'(w_idx);

    ohao_sine_rom u_sine_rom (
        .i_clk   (i_clk),
        .i_rd_en (w_issue),
        .i_addr  (w_addr),
        .o_data  (w_sine)
    );

    // rom data stage and product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= w_issue;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_a_neg  <= r_hp[PHASE_BITS-1];
            r_a_harm <= r_harm;
        end
        r_b_neg  <= r_a_neg;
        r_b_harm <= r_a_harm;
        r_b_prod <= PROD_BITS'(r_level) * PROD_BITS'(w_sine);
    end

    assign w_b_tag = '{valid: r_b_valid, neg: r_b_neg};

    ohao_div_pipe u_div_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (w_b_tag),
        .i_dividend (r_b_prod),
        .i_divisor  (r_b_harm),
        .o_tag      (w_q_tag),
        .o_quotient (w_quot)
    );

    // signed term, truncated toward zero by dividing the magnitude
    assign w_term = w_q_tag.neg ? -$signed(ACC_BITS'(w_quot)) : $signed(ACC_BITS'(w_quot));

    // round half up to q23 and saturate
    assign w_rounded = r_acc + ROUND_HALF;
    assign w_scaled  = w_rounded[ACC_BITS-1:FRAC_DROP];

    always_comb begin
        if (w_scaled > SAT_HI) begin
            w_sat = SAMPLE_BITS'(SAT_HI);
        end else if (w_scaled < SAT_LO) begin
            w_sat = SAMPLE_BITS'(SAT_LO);
        end else begin
            w_sat = w_scaled[SAMPLE_BITS-1:0];
        end
    end

    // harmonic phase walk and accumulator
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_hp    <= w_start_phase;
            r_step  <= w_start_phase << 1;
            r_harm  <= HARM_BITS'(1);
            r_level <= i_level;
            r_acc   <= '0;
        end else begin
            if (w_issue) begin
                r_hp   <= r_hp + r_step;
                r_harm <= r_harm + HARM_BITS'(2);
            end
            if (w_q_tag.valid) begin
                r_acc <= r_acc + w_term;
            end
        end
    end

    // sequencer, configuration, base phase and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_max_harmonic <= MAX_HARMONIC_RESET;
            r_base_phase   <= '0;
            r_left         <= '0;
            r_pend         <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_harmonic <= i_cfg_max_harmonic;
            end
            if (w_out_xfer && !w_finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_base_phase <= w_start_phase + INC_TABLE[i_note];
                        r_left       <= w_terms;
                        r_pend       <= w_terms;
                        r_state      <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_issue) begin
                        r_left <= r_left - HARM_BITS'(1);
                    end
                    if (w_q_tag.valid) begin
                        r_pend <= r_pend - HARM_BITS'(1);
                    end
                    if (w_finish) begin
                        r_out_valid <= 1'b1;
                        r_sample    <= w_sat;
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_odd_harmonic_additive_oscillator_unit.sv =====
// testbench for the odd-harmonic oscillator: directed ticks, then bursty random ticks
module tb_odd_harmonic_additive_oscillator_unit
    import ohao_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT       = 4_000_000;
    localparam int DRAIN_CYCLES    = 300;
    localparam int RANDOM_PHASES   = 10;
    localparam int TICKS_PER_PHASE = 153;
    localparam int HOLD_AFTER      = 300;
    localparam int HOLD_CYCLES     = 2500;

    // predictor formats: 32-bit phase, 1025-entry quarter wave in Q1.30
    localparam int                QWAVE_DEPTH = 1024;
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
    localparam longint            UNITY_Q30   = 64'sd1 <<< 30;
    localparam logic [63:0]       TICK_DENOM  = 64'd44100 * 64'd1000000000000;
    localparam logic [63:0]       RATIO_E12 [12] = '{
        64'd594603557501,  64'd629960524947,  64'd667419927085,  64'd707106781187,
        64'd749153538438,  64'd793700525984,  64'd840896415254,  64'd890898718140,
        64'd943874312682,  64'd1000000000000, 64'd1059463094359, 64'd1122462048309
    };

    // harmonic limits used by the random phases before random ones take over
    localparam int FIXED_LIMITS [7] = '{255, 1, 0, 3, 180, 254, 128};

    typedef struct packed {
        logic                          cfg_write;
        logic [HARM_BITS-1:0]          cfg_value;
        logic [NOTE_BITS-1:0]          note;
        logic [LEVEL_BITS-1:0]         level;
        logic                          restart;
        logic                          known;
        logic signed [SAMPLE_BITS-1:0] want;
    } t_tick_row;

    localparam int DIRECTED_ROWS = 20;

    // restart rows sit at phase zero, so every term is the sine of zero
    localparam t_tick_row DIRECTED_TICKS [DIRECTED_ROWS] = '{
        '{1'b0, 8'd0,   7'd69,  16'hFFFF, 1'b1, 1'b1, 24'sd0},
        '{1'b0, 8'd0,   7'd69,  16'hFFFF, 1'b0, 1'b0, 24'sd0},
        '{1'b0, 8'd0,   7'd127, 16'hFFFF, 1'b0, 1'b0, 24'sd0},
        '{1'b0, 8'd0,   7'd0,   16'h0000, 1'b0, 1'b1, 24'sd0},
        '{1'b0, 8'd0,   7'd0,   16'hFFFF, 1'b0, 1'b0, 24'sd0},
        '{1'b0, 8'd0,   7'd127, 16'h0001, 1'b0, 1'b0, 24'sd0},
        '{1'b0, 8'd0,   7'd42,  16'h8000, 1'b1, 1'b1, 24'sd0},
        '{1'b0, 8'd0,   7'd100, 16'hAAAA, 1'b0, 1'b0, 24'sd0},
        '{1'b1, 8'd0,   7'd69,  16'hFFFF, 1'b0, 1'b1, 24'sd0},
        '{1'b0, 8'd0,   7'd127, 16'hFFFF, 1'b0, 1'b1, 24'sd0},
        '{1'b1, 8'd1,   7'd69,  16'hFFFF, 1'b1, 1'b1, 24'sd0},
        '{1'b0, 8'd0,   7'd69,  16'hFFFF, 1'b0, 1'b0, 24'sd0},
        '{1'b0, 8'd0,   7'd81,  16'h5555, 1'b0, 1'b0, 24'sd0},
        '{1'b0, 8'd0,   7'd127, 16'hFFFF, 1'b0, 1'b0, 24'sd0},
        '{1'b1, 8'd255, 7'd33,  16'hFFFF, 1'b1, 1'b1, 24'sd0},
        '{1'b0, 8'd0,   7'd127, 16'hFFFF, 1'b0, 1'b0, 24'sd0},
        '{1'b0, 8'd0,   7'd0,   16'hFFFF, 1'b0, 1'b0, 24'sd0},
        '{1'b0, 8'd0,   7'd64,  16'h7FFF, 1'b0, 1'b0, 24'sd0},
        '{1'b1, 8'd2,   7'd90,  16'hFFFF, 1'b0, 1'b0, 24'sd0},
        '{1'b1, 8'd180, 7'd12,  16'h5555, 1'b0, 1'b0, 24'sd0}
    };

    logic                          i_clk              = 1'b0;
    logic                          i_rst_n            = 1'b0;
    logic                          i_in_valid         = 1'b0;
    logic                          o_in_ready;
    logic [NOTE_BITS-1:0]          i_note             = '0;
    logic [LEVEL_BITS-1:0]         i_level            = '0;
    logic                          i_restart          = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready        = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_sample;
    logic                          i_cfg_valid        = 1'b0;
    logic                          o_cfg_ready;
    logic [HARM_BITS-1:0]          i_cfg_max_harmonic = '0;

    // predictor state and tables
    logic [31:0]                   note_step [0:127];
    longint                        quarter_sin [0:QWAVE_DEPTH];
    logic [31:0]                   osc_phase      = '0;
    logic [HARM_BITS-1:0]          harmonic_limit = MAX_HARMONIC_RESET;
    logic signed [SAMPLE_BITS-1:0] pending_samples [$];
    logic signed [SAMPLE_BITS-1:0] want_sample;

    int errors         = 0;
    int samples_seen   = 0;
    int ticks_sent     = 0;
    int restarts_sent  = 0;
    int limits_written = 0;

    // output pacing state
    int   rx_mode     = 0;
    int   rx_mode_left = 0;
    int   rx_hold_left = 0;
    logic rx_held     = 1'b0;
    logic [2:0] rx_beat = '0;

    odd_harmonic_additive_oscillator_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_note             (i_note),
        .i_level            (i_level),
        .i_restart          (i_restart),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_sample           (o_sample),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_max_harmonic (i_cfg_max_harmonic)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // sum of odd harmonics at the current phase, zeroed first on a restart, then advance the phase
    function automatic logic signed [SAMPLE_BITS-1:0] next_sample(
        logic [NOTE_BITS-1:0] note, logic [LEVEL_BITS-1:0] level, logic restart);
        longint      sum;
        longint      amp;
        longint      rounded;
        logic [31:0] harm_phase;
        logic [9:0]  idx;
        if (restart) begin
            osc_phase = '0;
        end
        sum = 0;
        for (int h = 1; h <= harmonic_limit; h += 2) begin
            harm_phase = osc_phase * 32'(h);
            idx        = harm_phase[29:20];
            amp = harm_phase[30] ? quarter_sin[QWAVE_DEPTH - idx] : quarter_sin[idx];
            if (harm_phase[31]) begin
                amp = -amp;
            end
            sum += (longint'(level) * amp) / longint'(h);
        end
        osc_phase = osc_phase + note_step[note];
        rounded = (sum + (64'sd1 <<< 22)) >>> 23;
        if (rounded > 64'sd8388607) begin
            rounded = 64'sd8388607;
        end else if (rounded < -64'sd8388608) begin
            rounded = -64'sd8388608;
        end
        return SAMPLE_BITS'(rounded);
    endfunction

    // offer one tick and hold it until the transfer, then record what it should produce
    task automatic offer_tick(logic [NOTE_BITS-1:0] note, logic [LEVEL_BITS-1:0] level,
                              logic restart, logic known, logic signed [SAMPLE_BITS-1:0] want);
        logic signed [SAMPLE_BITS-1:0] predicted;
        i_in_valid <= 1'b1;
        i_note     <= note;
        i_level    <= level;
        i_restart  <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = next_sample(note, level, restart);
        pending_samples.push_back(known ? want : predicted);
        ticks_sent++;
        if (restart) begin
            restarts_sent++;
        end
    endtask

    // stop offering and wait for every outstanding sample
    task automatic wait_for_samples();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // harmonic limit update, only issued with the block idle
    task automatic write_harmonic_limit(logic [HARM_BITS-1:0] value);
        wait_for_samples();
        i_cfg_valid        <= 1'b1;
        i_cfg_max_harmonic <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        harmonic_limit  = value;
        limits_written++;
    endtask

    // output side: changing stall patterns plus one long hold-off
    always @(posedge i_clk) begin
        rx_beat <= rx_beat + 3'd1;
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_ready  <= 1'b0;
        end else if (!rx_held && samples_seen >= HOLD_AFTER) begin
            rx_held      <= 1'b1;
            rx_hold_left <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(50, 400);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_out_ready <= (rx_beat < 3'd3);
                end
            endcase
        end
    end

    // compare each sample transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            samples_seen++;
            if (pending_samples.size() == 0) begin
                errors++;
                $display("%0t: sample %0d arrived with nothing expected", $time, o_sample);
            end else begin
                want_sample = pending_samples.pop_front();
                if (o_sample !== want_sample) begin
                    errors++;
                    $display("%0t: sample mismatch, expected %0d, got %0d",
                             $time, want_sample, o_sample);
                end
            end
        end
    end

    // watchdog
    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("tb_odd_harmonic_additive_oscillator_unit: errors");
        $finish;
    end

    // stimulus
    initial begin
        logic [127:0]          scaled;
        logic [63:0]           x;
        logic [63:0]           term;
        longint                acc;
        int                    burst_left;
        int                    gap;
        logic [NOTE_BITS-1:0]  held_note;
        logic [LEVEL_BITS-1:0] lvl;
        logic                  rst_tick;
        logic [HARM_BITS-1:0]  limit_value;

        // phase step per note, rounded half up
        for (int n = 0; n < 128; n++) begin
            scaled = {64'd0, 64'd440 * RATIO_E12[n % 12]} << (28 + n / 12);
            scaled = scaled / {64'd0, TICK_DENOM};
            note_step[n] = 32'((scaled + 128'd1) >> 1);
        end

        // quarter-wave sine by truncated taylor series, clamped to unity
        for (int j = 0; j <= QWAVE_DEPTH; j++) begin
            x    = (HALF_PI_Q30 * 64'(j) + 64'(QWAVE_DEPTH / 2)) / 64'(QWAVE_DEPTH);
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 9; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > UNITY_Q30) begin
                acc = UNITY_Q30;
            end
            quarter_sin[j] = acc;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED_TICKS[r].cfg_write) begin
                write_harmonic_limit(DIRECTED_TICKS[r].cfg_value);
            end
            offer_tick(DIRECTED_TICKS[r].note, DIRECTED_TICKS[r].level,
                       DIRECTED_TICKS[r].restart, DIRECTED_TICKS[r].known,
                       DIRECTED_TICKS[r].want);
        end

        // random phases: held notes with occasional restarts, sent in bursts
        held_note  = 7'($urandom_range(0, 127));
        burst_left = 0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            limit_value = (p < 7) ? HARM_BITS'(FIXED_LIMITS[p])
                                  : HARM_BITS'($urandom_range(1, 255));
            write_harmonic_limit(limit_value);
            for (int t = 0; t < TICKS_PER_PHASE; t++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 250);
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                rst_tick = ($urandom_range(0, 19) == 0);
                if (rst_tick || $urandom_range(0, 9) == 0) begin
                    held_note = 7'($urandom_range(0, 127));
                end
                case ($urandom_range(0, 7))
                    0:       lvl = 16'hFFFF;
                    1:       lvl = 16'h0000;
                    2:       lvl = 16'($urandom_range(0, 255));
                    default: lvl = 16'($urandom_range(0, 65535));
                endcase
                offer_tick(held_note, lvl, rst_tick, 1'b0, '0);
                burst_left--;
            end
        end

        wait_for_samples();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_samples.size() != 0) begin
            errors++;
            $display("%0t: %0d samples never arrived", $time, pending_samples.size());
        end
        $display("%0d ticks sent (%0d restarts) across %0d harmonic limit writes",
                 ticks_sent, restarts_sent, limits_written);
        $display("%0d samples compared, %0d errors", samples_seen, errors);
        if (errors == 0) begin
            $display("tb_odd_harmonic_additive_oscillator_unit: clean");
        end else begin
            $display("tb_odd_harmonic_additive_oscillator_unit: errors");
        end
        $finish;
    end

endmodule
